### hw/rtl/qsu_pkg.sv
package qsu_pkg;

    // counter width default
    localparam int QSU_POSITION_BITS = 24;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int CODE_W   = 3;
    localparam int REPORT_W = 24;

    // result tdata layout, lowest bit first
    localparam int OUT_CHAR_LSB  = 0;
    localparam int OUT_SEEN_LSB  = OUT_CHAR_LSB + BYTE_W;
    localparam int OUT_CODE_LSB  = OUT_SEEN_LSB + 1;
    localparam int OUT_POS_LSB   = OUT_CODE_LSB + CODE_W;
    localparam int OUT_LINE_LSB  = OUT_POS_LSB + REPORT_W;
    localparam int OUT_COL_LSB   = OUT_LINE_LSB + REPORT_W;
    localparam int OUT_NOW_LSB   = OUT_COL_LSB + REPORT_W;
    localparam int OUT_USED_W    = OUT_NOW_LSB + REPORT_W;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // scan phases
    localparam logic [1:0] PH_OPEN = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;

    // error codes
    localparam logic [CODE_W-1:0] ERR_NONE = 3'd0;
    localparam logic [CODE_W-1:0] ERR_CTRL = 3'd1;
    localparam logic [CODE_W-1:0] ERR_LINE = 3'd2;
    localparam logic [CODE_W-1:0] ERR_UNI  = 3'd3;
    localparam logic [CODE_W-1:0] ERR_ESC  = 3'd4;

    // quote register reset value
    localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'h22;

    // character codes
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LOW_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;

endpackage

### hw/rtl/quoted_string_unescape_scanner_core.sv
// latency: a result beat appears in the cycle after its input beat is accepted
// throughput: one byte per cycle, set by the single result register that
// decouples the two sides; input is taken whenever that register is empty or drained
// reset: rst_n is asynchronous and active low; it clears phase, position, line start,
// latched error and result valid, sets line count to 1 and loads quote_reg with 0x22
module quoted_string_unescape_scanner_core
    import qsu_pkg::*;
#(
    parameter int POSITION_BITS = QSU_POSITION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [BYTE_W-1:0]     cfg_wdata,       // quote_char
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,    // in_byte
    input  logic                  s_axis_tlast,    // at_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_char, error_seen, error_code, error_position, error_line,
    // error_column, line_now, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,    // string_done
    output logic                  m_axis_tuser     // char_valid
);

    // state
    logic [BYTE_W-1:0]        quote_reg;
    logic [1:0]               phase_reg, phase_next;
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [POSITION_BITS-1:0] line_count_reg, line_count_next;
    logic [POSITION_BITS-1:0] line_start_reg, line_start_next;
    logic                     err_flag_reg, err_flag_next;
    logic [CODE_W-1:0]        err_kind_reg, err_kind_next;
    logic [POSITION_BITS-1:0] err_offset_reg, err_offset_next;
    logic [POSITION_BITS-1:0] err_line_reg, err_line_next;
    logic [POSITION_BITS-1:0] err_col_reg, err_col_next;

    // result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_user_reg;

    logic                     accept;
    logic                     char_valid;
    logic [BYTE_W-1:0]        out_char;
    logic                     string_done;
    logic                     lat_en;
    logic [CODE_W-1:0]        lat_kind;
    logic [POSITION_BITS-1:0] position_inc;
    logic [OUT_DATA_W-1:0]    result_data;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign position_inc  = position_reg + POSITION_BITS'(1);

    // per-byte phase step, decode and error detection
    always_comb
    begin
        phase_next      = phase_reg;
        position_next   = position_reg;
        line_count_next = line_count_reg;
        line_start_next = line_start_reg;
        char_valid      = 1'b0;
        out_char        = CH_NUL;
        string_done     = 1'b0;
        lat_en          = 1'b0;
        lat_kind        = ERR_NONE;

        if (s_axis_tlast)
        begin
            if (phase_reg == PH_ESC)
            begin
                lat_en   = 1'b1;
                lat_kind = ERR_ESC;
            end
            if (phase_reg != PH_OPEN)
            begin
                string_done = 1'b1;
                phase_next  = PH_OPEN;
            end
        end
        else
        begin
            position_next = position_inc;
            if (s_axis_tdata == CH_NL)
            begin
                line_count_next = line_count_reg + POSITION_BITS'(1);
                line_start_next = position_inc;
            end

            case (phase_reg)
                PH_OPEN:
                begin
                    phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    if (s_axis_tdata == quote_reg)
                    begin
                        string_done = 1'b1;
                        phase_next  = PH_OPEN;
                    end
                    else if (s_axis_tdata == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        if (s_axis_tdata inside {CH_NUL, CH_BS, CH_TAB})
                        begin
                            lat_en   = 1'b1;
                            lat_kind = ERR_CTRL;
                        end
                        else if (s_axis_tdata inside {CH_CR, CH_NL})
                        begin
                            lat_en   = 1'b1;
                            lat_kind = ERR_LINE;
                        end
                        char_valid = 1'b1;
                        out_char   = s_axis_tdata;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_BODY;
                    char_valid = 1'b1;
                    case (s_axis_tdata)
                        CH_DQUOTE: out_char = CH_DQUOTE;
                        CH_BSLASH: out_char = CH_BSLASH;
                        CH_SLASH:  out_char = CH_SLASH;
                        CH_LOW_B:  out_char = CH_BS;
                        CH_LOW_F:  out_char = CH_FF;
                        CH_LOW_N:  out_char = CH_NL;
                        CH_LOW_R:  out_char = CH_CR;
                        CH_LOW_T:  out_char = CH_TAB;
                        CH_LOW_U:
                        begin
                            char_valid = 1'b0;
                            lat_en     = 1'b1;
                            lat_kind   = ERR_UNI;
                        end
                        default:
                        begin
                            char_valid = 1'b0;
                            lat_en     = 1'b1;
                            lat_kind   = ERR_ESC;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_OPEN;
                end
            endcase
        end
    end

    // first error wins, placed at the line that held before the byte
    always_comb
    begin
        err_flag_next   = err_flag_reg;
        err_kind_next   = err_kind_reg;
        err_offset_next = err_offset_reg;
        err_line_next   = err_line_reg;
        err_col_next    = err_col_reg;
        if (lat_en && !err_flag_reg)
        begin
            err_flag_next   = 1'b1;
            err_kind_next   = lat_kind;
            err_offset_next = position_reg;
            err_line_next   = line_count_reg;
            err_col_next    = position_reg - line_start_reg;
        end
    end

    // pack the result beat
    always_comb
    begin
        result_data = '0;
        result_data[OUT_CHAR_LSB +: BYTE_W]   = out_char;
        result_data[OUT_SEEN_LSB]             = err_flag_next;
        result_data[OUT_CODE_LSB +: CODE_W]   = err_kind_next;
        result_data[OUT_POS_LSB +: REPORT_W]  = REPORT_W'(err_offset_next);
        result_data[OUT_LINE_LSB +: REPORT_W] = REPORT_W'(err_line_next);
        result_data[OUT_COL_LSB +: REPORT_W]  = REPORT_W'(err_col_next);
        result_data[OUT_NOW_LSB +: REPORT_W]  = REPORT_W'(line_count_next);
    end

    // quote register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quote_reg <= QUOTE_RESET;
        else if (cfg_we)
            quote_reg <= cfg_wdata;
    end

    // scan state and latched error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPEN;
            position_reg   <= '0;
            line_count_reg <= POSITION_BITS'(1);
            line_start_reg <= '0;
            err_flag_reg   <= 1'b0;
            err_kind_reg   <= ERR_NONE;
            err_offset_reg <= '0;
            err_line_reg   <= '0;
            err_col_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            position_reg   <= position_next;
            line_count_reg <= line_count_next;
            line_start_reg <= line_start_next;
            err_flag_reg   <= err_flag_next;
            err_kind_reg   <= err_kind_next;
            err_offset_reg <= err_offset_next;
            err_line_reg   <= err_line_next;
            err_col_reg    <= err_col_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result_data;
            out_last_reg <= string_done;
            out_user_reg <= char_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

### hw/rtl/qsu_checker.sv
module qsu_checker
    import qsu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tuser
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // an empty result register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a decoded character never closes a string
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
        else $error("character and string end in one beat");

    // error flag and error code agree
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_SEEN_LSB] ==
            (m_axis_tdata[OUT_CODE_LSB +: CODE_W] != ERR_NONE)))
        else $error("error flag and code disagree");

endmodule

bind quoted_string_unescape_scanner_core qsu_checker u_qsu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import qsu_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 9;
    localparam int STALL_MAX  = 4000;
    localparam int HOLD_LEN   = 300;
    localparam int CHUNK      = 200;

    // one decoded result beat, unpacked
    typedef struct packed {
        logic                char_valid;
        logic [BYTE_W-1:0]   out_char;
        logic                string_done;
        logic                error_seen;
        logic [CODE_W-1:0]   error_code;
        logic [REPORT_W-1:0] error_position;
        logic [REPORT_W-1:0] error_line;
        logic [REPORT_W-1:0] error_column;
        logic [REPORT_W-1:0] line_now;
    } scan_result_t;

    // scanner model plus queue of results still owed by the block
    class scan_scoreboard;
        logic [BYTE_W-1:0]   quote;
        logic [1:0]          phase;
        logic [REPORT_W-1:0] offset;
        logic [REPORT_W-1:0] line_cnt;
        logic [REPORT_W-1:0] line_head;
        logic                err_latched;
        logic [CODE_W-1:0]   err_code;
        logic [REPORT_W-1:0] err_at;
        logic [REPORT_W-1:0] err_ln;
        logic [REPORT_W-1:0] err_col;
        scan_result_t        owed[$];
        int                  mismatches;

        function new();
            quote       = QUOTE_RESET;
            phase       = PH_OPEN;
            offset      = '0;
            line_cnt    = REPORT_W'(1);
            line_head   = '0;
            err_latched = 1'b0;
            err_code    = ERR_NONE;
            err_at      = '0;
            err_ln      = '0;
            err_col     = '0;
            mismatches  = 0;
        endfunction

        // only the first error sticks
        function void note_error(logic [CODE_W-1:0] code, logic [REPORT_W-1:0] at,
                                 logic [REPORT_W-1:0] ln, logic [REPORT_W-1:0] head);
            if (!err_latched)
            begin
                err_latched = 1'b1;
                err_code    = code;
                err_at      = at;
                err_ln      = ln;
                err_col     = at - head;
            end
        endfunction

        // advance the model by one accepted source beat
        function void take_source_beat(logic [BYTE_W-1:0] b, logic at_end);
            scan_result_t        r;
            logic [REPORT_W-1:0] at;
            logic [REPORT_W-1:0] ln;
            logic [REPORT_W-1:0] head;
            r = '0;
            if (at_end)
            begin
                if (phase == PH_ESC)
                    note_error(ERR_ESC, offset, line_cnt, line_head);
                if (phase != PH_OPEN)
                begin
                    r.string_done = 1'b1;
                    phase = PH_OPEN;
                end
            end
            else
            begin
                at     = offset;
                ln     = line_cnt;
                head   = line_head;
                offset = offset + 1'b1;
                if (b == CH_NL)
                begin
                    line_cnt  = line_cnt + 1'b1;
                    line_head = offset;
                end
                if (phase == PH_OPEN)
                    phase = PH_BODY;
                else if (phase == PH_BODY)
                begin
                    if (b == quote)
                    begin
                        r.string_done = 1'b1;
                        phase = PH_OPEN;
                    end
                    else if (b == CH_BSLASH)
                        phase = PH_ESC;
                    else
                    begin
                        if (b == CH_NUL || b == CH_BS || b == CH_TAB)
                            note_error(ERR_CTRL, at, ln, head);
                        else if (b == CH_CR || b == CH_NL)
                            note_error(ERR_LINE, at, ln, head);
                        r.char_valid = 1'b1;
                        r.out_char   = b;
                    end
                end
                else
                begin
                    // escape byte, never a closing quote
                    phase = PH_BODY;
                    r.char_valid = 1'b1;
                    case (b)
                        CH_DQUOTE: r.out_char = CH_DQUOTE;
                        CH_BSLASH: r.out_char = CH_BSLASH;
                        CH_SLASH:  r.out_char = CH_SLASH;
                        CH_LOW_B:  r.out_char = CH_BS;
                        CH_LOW_F:  r.out_char = CH_FF;
                        CH_LOW_N:  r.out_char = CH_NL;
                        CH_LOW_R:  r.out_char = CH_CR;
                        CH_LOW_T:  r.out_char = CH_TAB;
                        CH_LOW_U:
                        begin
                            r.char_valid = 1'b0;
                            note_error(ERR_UNI, at, ln, head);
                        end
                        default:
                        begin
                            r.char_valid = 1'b0;
                            note_error(ERR_ESC, at, ln, head);
                        end
                    endcase
                end
            end
            r.error_seen     = err_latched;
            r.error_code     = err_code;
            r.error_position = err_at;
            r.error_line     = err_ln;
            r.error_column   = err_col;
            r.line_now       = line_cnt;
            owed = {owed, r};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        // compare one result beat with the oldest owed result
        function void check_result_beat(logic [OUT_DATA_W-1:0] data, logic last, logic user);
            scan_result_t w;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result beat %0h with nothing pending", data);
                return;
            end
            w = owed.pop_front();
            compare_field("char_valid", w.char_valid, user);
            compare_field("out_char", w.out_char, data[OUT_CHAR_LSB +: BYTE_W]);
            compare_field("string_done", w.string_done, last);
            compare_field("error_seen", w.error_seen, data[OUT_SEEN_LSB]);
            compare_field("error_code", w.error_code, data[OUT_CODE_LSB +: CODE_W]);
            compare_field("error_position", w.error_position,
                          data[OUT_POS_LSB +: REPORT_W]);
            compare_field("error_line", w.error_line, data[OUT_LINE_LSB +: REPORT_W]);
            compare_field("error_column", w.error_column, data[OUT_COL_LSB +: REPORT_W]);
            compare_field("line_now", w.line_now, data[OUT_NOW_LSB +: REPORT_W]);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [BYTE_W-1:0]     cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    scan_scoreboard    sb = new();
    int                send_idle_pct = 34;
    int                recv_idle_pct = 61;
    int                hold_requests = 0;
    int                bytes_sent = 0;
    logic [BYTE_W-1:0] cur_quote = QUOTE_RESET;

    quoted_string_unescape_scanner_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // reset
    initial
    begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result side: random backpressure, long hold on request
    initial
    begin
        int holds_served;
        int k;
        holds_served = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_requests > holds_served)
            begin
                holds_served++;
                m_axis_tready <= 1'b0;
                for (k = 0; k < HOLD_LEN; k++)
                    @(posedge clk);
            end
            m_axis_tready <= !($urandom_range(99) < recv_idle_pct);
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    // watchdog on cycles with no beat moving
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_MAX)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // offer one source beat and wait for it to be taken
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic at_end);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= at_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.take_source_beat(b, at_end);
        if (!at_end)
            bytes_sent++;
    endtask

    task automatic send_end();
        send_beat(BYTE_W'($urandom_range(255)), 1'b1);
    endtask

    // drain everything owed, then let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_quote(input logic [BYTE_W-1:0] q);
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.quote  = q;
        cur_quote = q;
    endtask

    // body byte that neither closes the string nor starts an escape
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do
        begin
            if ($urandom_range(4) == 0)
                b = BYTE_W'($urandom_range(128, 255));
            else
                b = BYTE_W'($urandom_range(32, 126));
        end
        while (b == cur_quote || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] escape_byte();
        logic [BYTE_W-1:0] known[9];
        int                r;
        known = '{CH_DQUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F,
                  CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_U};
        r = $urandom_range(99);
        if (r < 85)
            return known[$urandom_range(7)];
        else if (r < 92)
            return CH_LOW_U;
        else
            return BYTE_W'($urandom_range(255));
    endfunction

    // one string with random content and a random way of ending
    task automatic send_string();
        int                len;
        int                k;
        int                r;
        logic [BYTE_W-1:0] opener;
        r = $urandom_range(9);
        if (r == 0)
            opener = CH_NL;
        else if (r == 1)
            opener = BYTE_W'($urandom_range(255));
        else
            opener = cur_quote;
        send_beat(opener, 1'b0);
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
        for (k = 0; k < len; k++)
        begin
            r = $urandom_range(99);
            if (r < 78)
                send_beat(plain_byte(), 1'b0);
            else if (r < 92)
            begin
                send_beat(CH_BSLASH, 1'b0);
                send_beat(escape_byte(), 1'b0);
            end
            else
                send_beat(BYTE_W'($urandom_range(255)), 1'b0);
        end
        r = $urandom_range(99);
        if (r < 85)
            send_beat(cur_quote, 1'b0);
        else if (r < 93)
            send_end();
        else if (r < 97)
        begin
            send_beat(CH_BSLASH, 1'b0);
            send_end();
        end
    endtask

    // raw noise, end markers sprinkled in
    task automatic send_noise();
        int n;
        int k;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            send_beat(BYTE_W'($urandom_range(255)), ($urandom_range(7) == 0));
    endtask

    // main sequence
    initial
    begin
        logic [BYTE_W-1:0] quotes[6];
        int                chunk;
        int                target;
        quotes = '{8'h27, 8'h00, 8'hFF, CH_BSLASH, 8'h00, QUOTE_RESET};
        quotes[4] = BYTE_W'($urandom_range(255));
        @(posedge clk iff rst_n);

        // directed: reset quote, every escape, byte extremes, first error
        send_end();
        send_beat(CH_NL, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CH_BSLASH, 1'b0); send_beat(CH_DQUOTE, 1'b0);
        send_beat(CH_BSLASH, 1'b0); send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_BSLASH, 1'b0); send_beat(CH_SLASH, 1'b0);
        send_beat(CH_BSLASH, 1'b0); send_beat(CH_LOW_B, 1'b0);
        send_beat(CH_BSLASH, 1'b0); send_beat(CH_LOW_F, 1'b0);
        send_beat(CH_BSLASH, 1'b0); send_beat(CH_LOW_N, 1'b0);
        send_beat(CH_BSLASH, 1'b0); send_beat(CH_LOW_R, 1'b0);
        send_beat(CH_BSLASH, 1'b0); send_beat(CH_LOW_T, 1'b0);
        send_beat(CH_DQUOTE, 1'b0);
        send_beat(CH_NUL, 1'b0);
        send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_LOW_U, 1'b0);
        send_beat(CH_NUL, 1'b0);
        send_end();

        // random part in chunks, each with a new quote; chunk pairs share an idle pattern
        for (chunk = 0; chunk < 6; chunk++)
        begin
            wait_idle();
            write_quote(quotes[chunk]);
            if (chunk < 2)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 61;
            end
            else if (chunk < 4)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (chunk == 4)
                hold_requests = hold_requests + 1;
            target = bytes_sent + CHUNK;
            while (bytes_sent < target)
            begin
                if ($urandom_range(19) == 0)
                    send_noise();
                else
                    send_string();
            end
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
